[design/ordered_byte_list_unit_assert.svh]
// Assertion macros for the ordered byte list unit
`ifndef ORDERED_BYTE_LIST_UNIT_ASSERT_SVH
`define ORDERED_BYTE_LIST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define OBL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered byte list: check failed");
`define OBL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered byte list: check failed");
`else
`define OBL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define OBL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[design/obl_pkg.sv]
// Shared constants, codes and types of the ordered byte list unit
`timescale 1ns / 1ps
package obl_pkg;
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 8;
   localparam int POS_W    = 4;
   localparam int LEN_W    = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      OP_APPEND       = 2'd0,
      OP_INSERT_AFTER = 2'd1,
      OP_DELETE       = 2'd2,
      OP_GET          = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [VAL_W-1:0] read_value;
      logic [LEN_W-1:0] length;
      status_type       status;
   } result_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;
endpackage

[design/obl_if.sv]
// Command and result channel interfaces
`timescale 1ns / 1ps
interface obl_req_if import obl_pkg::*;;
   logic                valid;
   logic                ready;
   op_type              operation;
   logic [VAL_W-1:0]    value;
   logic [POS_W-1:0]    position;

   modport source (output valid, output operation, output value, output position,
                   input ready);
   modport sink   (input valid, input operation, input value, input position,
                   output ready);
endinterface

interface obl_rsp_if import obl_pkg::*;;
   logic                valid;
   logic                ready;
   logic [VAL_W-1:0]    read_value;
   logic [LEN_W-1:0]    length;
   status_type          status;

   modport source (output valid, output read_value, output length, output status,
                   input ready);
   modport sink   (input valid, input read_value, input length, input status,
                   output ready);
endinterface

[design/obl_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle
`timescale 1ns / 1ps
module obl_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[design/obl_seq.sv]
// Command sequencer: decodes a command and walks the list memory
`timescale 1ns / 1ps
module obl_seq import obl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   obl_req_if.sink          req_if,
   output mem_req_type      mem_req,
   input  logic [VAL_W-1:0] mem_rd_data,
   output logic             res_valid,
   output result_type       res,
   input  logic             slot_free,
   output logic [CNT_W-1:0] count
);
   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_EXEC     = 7'b0000010,
      S_GET      = 7'b0000100,
      S_SHIFT_UP = 7'b0001000,
      S_SEARCH   = 7'b0010000,
      S_SHIFT_DN = 7'b0100000,
      S_DONE     = 7'b1000000
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   op_type           op_ff, op_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [VAL_W-1:0] rv_ff, rv_in;
   status_type       st_ff, st_in;

   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic             full;
   logic             pos_ok;
   logic             issue_up;
   logic             issue_fwd;

   assign pos_cmp   = CMP_W'(pos_ff);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign pos_ok    = (pos_cmp < cnt_cmp);
   // shift-up reads walk down to the entry just behind position
   assign issue_up  = (CMP_W'(ptr_ff) > pos_cmp);
   assign issue_fwd = (ptr_ff < count_ff);

   assign count = count_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      rv_in       = rv_ff;
      st_in       = st_ff;
      mem_req     = '0;
      req_if.ready = 1'b0;
      res_valid   = 1'b0;
      res.read_value = rv_ff;
      res.length     = LEN_W'(count_ff);
      res.status     = st_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               op_in    = req_if.operation;
               value_in = req_if.value;
               pos_in   = req_if.position;
               rv_in    = '0;
               st_in    = ST_OK;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_APPEND: begin
                  state_in = S_DONE;
                  if (full) begin
                     st_in = ST_FULL;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = IDX_W'(count_ff);
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + CNT_W'(1);
                  end
               end
               OP_INSERT_AFTER: begin
                  if (full) begin
                     st_in    = ST_FULL;
                     state_in = S_DONE;
                  end else if (!pos_ok) begin
                     st_in    = ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     ptr_in   = count_ff - CNT_W'(1);
                     state_in = S_SHIFT_UP;
                  end
               end
               OP_DELETE: begin
                  if (count_ff == '0) begin
                     st_in    = ST_NOT_FOUND;
                     state_in = S_DONE;
                  end else begin
                     ptr_in   = '0;
                     state_in = S_SEARCH;
                  end
               end
               OP_GET: begin
                  if (!pos_ok) begin
                     st_in    = ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = IDX_W'(pos_ff);
                     state_in        = S_GET;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_GET: begin
            rv_in    = mem_rd_data;
            state_in = S_DONE;
         end
         S_SHIFT_UP: begin
            if (issue_up) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(ptr_ff);
               ptr_in          = ptr_ff - CNT_W'(1);
               rd_valid_in     = 1'b1;
               rd_idx_in       = IDX_W'(ptr_ff);
            end
            if (rd_valid_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_idx_ff + IDX_W'(1);
               mem_req.wr_data = mem_rd_data;
            end else if (!issue_up) begin
               // gap is open: drop the new byte in behind position
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = IDX_W'(pos_cmp + CMP_W'(1));
               mem_req.wr_data = value_ff;
               count_in        = count_ff + CNT_W'(1);
               state_in        = S_DONE;
            end
         end
         S_SEARCH: begin
            if (issue_fwd) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(ptr_ff);
               ptr_in          = ptr_ff + CNT_W'(1);
               rd_valid_in     = 1'b1;
               rd_idx_in       = IDX_W'(ptr_ff);
            end
            if (rd_valid_ff) begin
               if (mem_rd_data == value_ff) begin
                  // read of the next entry, if any, is already in flight
                  state_in = S_SHIFT_DN;
               end else if (CNT_W'(rd_idx_ff) + CNT_W'(1) == count_ff) begin
                  st_in    = ST_NOT_FOUND;
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT_DN: begin
            if (issue_fwd) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(ptr_ff);
               ptr_in          = ptr_ff + CNT_W'(1);
               rd_valid_in     = 1'b1;
               rd_idx_in       = IDX_W'(ptr_ff);
            end
            if (rd_valid_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_idx_ff - IDX_W'(1);
               mem_req.wr_data = mem_rd_data;
            end else if (!issue_fwd) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      rd_idx_ff <= rd_idx_in;
      rv_ff     <= rv_in;
      st_ff     <= st_in;
   end
endmodule

[design/obl_rsp_reg.sv]
// Result output register between the sequencer and the result channel
`timescale 1ns / 1ps
module obl_rsp_reg import obl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       slot_free,
   obl_rsp_if.source  rsp_if
);
   logic       valid_ff, valid_in;
   result_type data_ff, data_in;
   logic       load;

   assign slot_free = !valid_ff || rsp_if.ready;
   assign load      = res_valid && slot_free;
   assign valid_in  = load || (valid_ff && !rsp_if.ready);
   assign data_in   = load ? res : data_ff;

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.read_value = data_ff.read_value;
   assign rsp_if.length     = data_ff.length;
   assign rsp_if.status     = data_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
endmodule

[design/ordered_byte_list_unit.sv]
// Ordered byte list unit: top level
//
//   channel   dir   beat contents
//   req_if    in    operation, value, position
//   rsp_if    out   read_value, length, status
//
// One command at a time. A command is accepted, then decoded; append then
// writes at once, get reads one entry, insert-after shifts the entries behind
// position up, delete searches for the value and shifts the rest down, all by
// the single list RAM stepping one entry per cycle; the result is registered.
// Reset clears the entry count and the control state; the list RAM is not cleared.
// A stalled result beat sits in the output register while the next command
// is taken; a finished command waits for that register to free up.
`timescale 1ns / 1ps
`include "ordered_byte_list_unit_assert.svh"
module ordered_byte_list_unit import obl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   obl_req_if.sink   req_if,
   obl_rsp_if.source rsp_if
);
   mem_req_type      mem_req;
   logic [VAL_W-1:0] mem_rd_data;
   logic             res_valid;
   result_type       res;
   logic             slot_free;
   logic [CNT_W-1:0] count;

   obl_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .slot_free   (slot_free),
      .count       (count)
   );

   obl_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VAL_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   obl_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_if    (rsp_if)
   );

   `OBL_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count <= CNT_W'(CAPACITY))
   `OBL_ASSERT_NXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   `OBL_ASSERT_IMP(a_fail_reads_zero, clock, reset, rsp_if.valid && rsp_if.status != ST_OK, rsp_if.read_value == '0)
   `OBL_ASSERT_IMP(a_full_length, clock, reset, rsp_if.valid && rsp_if.status == ST_FULL, rsp_if.length == LEN_W'(CAPACITY))
endmodule

[tb/tb_ordered_byte_list_unit.sv]
// Self-checking testbench for the ordered byte list unit
`timescale 1ns / 1ps
module tb_ordered_byte_list_unit import obl_pkg::*; ();

   localparam int RANDOM_COMMANDS = 1675;
   localparam int MAX_GAP         = 14;
   localparam int LONG_HOLD       = 90;
   localparam int TAIL_CYCLES     = CAPACITY + 10;
   localparam int STALL_LIMIT     = 1000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      op_type           op;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      bit               drain_first;   // hold back until every result is back
   } list_command_type;

   typedef struct {
      logic [VAL_W-1:0] bytes [CAPACITY];
      int unsigned      count;
   } list_image_type;

   typedef struct {
      op_type     op;
      result_type res;
   } expected_beat_type;

   logic clock;
   logic reset;

   obl_req_if req_bus ();
   obl_rsp_if rsp_bus ();

   ordered_byte_list_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   list_command_type  command_queue [$];
   expected_beat_type expected_results [$];
   list_image_type    list_plan;      // shadow used while shaping the stimulus
   list_image_type    list_now;       // list as the block should hold it
   list_command_type  current_cmd;
   bit             offering;
   bit             sender_steady;
   bit             receiver_steady;
   int unsigned    send_wait;
   int unsigned    sink_wait;
   int unsigned    hold_left;
   int unsigned    results_seen;
   int unsigned    faults;
   int unsigned    idle_cycles;
   int unsigned    op_seen [4];
   int unsigned    status_seen [4];

   // Applies one command to a list image and returns the result beat it gives
   function automatic result_type run_command(inout list_image_type img,
                                              input list_command_type cmd);
      result_type  res;
      int unsigned k;
      int unsigned hit;
      res.read_value = '0;
      res.status     = ST_OK;
      case (cmd.op)
         OP_APPEND: begin
            if (img.count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               img.bytes[img.count] = cmd.value;
               img.count++;
            end
         end
         OP_INSERT_AFTER: begin
            // fullness is tested before the position
            if (img.count >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (cmd.position >= img.count) begin
               res.status = ST_RANGE;
            end else begin
               for (k = img.count; k > cmd.position + 1; k--)
                  img.bytes[k] = img.bytes[k - 1];
               img.bytes[cmd.position + 1] = cmd.value;
               img.count++;
            end
         end
         OP_DELETE: begin
            hit = img.count;
            for (k = 0; k < img.count; k++) begin
               if (hit == img.count && img.bytes[k] == cmd.value)
                  hit = k;
            end
            if (hit >= img.count) begin
               res.status = ST_NOT_FOUND;
            end else begin
               for (k = hit; k + 1 < img.count; k++)
                  img.bytes[k] = img.bytes[k + 1];
               img.count--;
            end
         end
         default: begin
            if (cmd.position < img.count)
               res.read_value = img.bytes[cmd.position];
            else
               res.status = ST_RANGE;
         end
      endcase
      res.length = LEN_W'(img.count);
      return res;
   endfunction

   task automatic queue_command(input op_type op, input int unsigned value,
                                input int unsigned position, input bit drain_first);
      list_command_type cmd;
      result_type       ignored;
      cmd.op          = op;
      cmd.value       = VAL_W'(value);
      cmd.position    = POS_W'(position);
      cmd.drain_first = drain_first;
      ignored         = run_command(list_plan, cmd);
      command_queue.push_back(cmd);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Command driver
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         send_wait = 0;
         sender_steady = 1'b0;
         req_bus.valid <= 1'b0;
      end else begin
         if (offering && req_bus.ready) begin
            expected_results.push_back('{current_cmd.op, run_command(list_now, current_cmd)});
            offering = 1'b0;
            if ($urandom_range(0, 39) == 0)
               sender_steady = !sender_steady;
            send_wait = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (command_queue.size() != 0 &&
                         !(command_queue[0].drain_first && expected_results.size() != 0)) begin
               current_cmd = command_queue.pop_front();
               offering = 1'b1;
               req_bus.operation <= current_cmd.op;
               req_bus.value     <= current_cmd.value;
               req_bus.position  <= current_cmd.position;
            end
         end
         req_bus.valid <= offering;
      end
   end

   // Result monitor and receiver stalls
   always @(posedge clock) begin
      expected_beat_type want;
      if (reset) begin
         sink_wait = 0;
         hold_left = 0;
         receiver_steady = 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               faults++;
               if (faults <= REPORT_LIMIT)
                  $display("unexpected result beat: value %02h length %0d status %0d",
                           rsp_bus.read_value, rsp_bus.length, rsp_bus.status);
            end else begin
               want = expected_results.pop_front();
               op_seen[want.op]++;
               status_seen[want.res.status]++;
               if (rsp_bus.read_value !== want.res.read_value ||
                   rsp_bus.length !== want.res.length ||
                   rsp_bus.status !== want.res.status) begin
                  faults++;
                  if (faults <= REPORT_LIMIT)
                     $display("mismatch on %s, beat %0d: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                              want.op.name(), results_seen, want.res.read_value,
                              want.res.length, want.res.status, rsp_bus.read_value,
                              rsp_bus.length, rsp_bus.status);
               end
            end
            if ($urandom_range(0, 39) == 0)
               receiver_steady = !receiver_steady;
            sink_wait = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
            // long back-pressure so the unit fills and stalls its input
            if (results_seen == 400 || results_seen == 1300)
               hold_left = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if (sink_wait > 0) begin
            sink_wait--;
         end
         rsp_bus.ready <= (hold_left == 0 && sink_wait == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("ordered_byte_list_unit regression: fail");
      $finish;
   end

   initial begin
      int unsigned n;
      int unsigned len;
      int unsigned roll;
      bit          growing;
      bit          narrow;
      op_type      op;
      int unsigned value;
      int unsigned position;

      reset = 1'b1;
      idle_cycles = 0;
      results_seen = 0;
      faults = 0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_APPEND;
      req_bus.value = '0;
      req_bus.position = '0;
      rsp_bus.ready = 1'b0;
      for (n = 0; n < 4; n++) begin
         op_seen[n] = 0;
         status_seen[n] = 0;
      end
      for (n = 0; n < CAPACITY; n++) begin
         list_plan.bytes[n] = '0;
         list_now.bytes[n] = '0;
      end
      list_plan.count = 0;
      list_now.count = 0;

      // directed: empty list and short list corner cases
      queue_command(OP_GET, 8'h00, 0, 1'b0);
      queue_command(OP_DELETE, 8'h00, 0, 1'b0);
      queue_command(OP_INSERT_AFTER, 8'hFF, 0, 1'b0);
      queue_command(OP_APPEND, 8'h00, 15, 1'b0);
      queue_command(OP_APPEND, 8'hFF, 0, 1'b0);
      queue_command(OP_APPEND, 8'h5A, 0, 1'b0);
      queue_command(OP_INSERT_AFTER, 8'hA5, 0, 1'b0);
      queue_command(OP_INSERT_AFTER, 8'hFF, 3, 1'b0);   // behind the last entry
      queue_command(OP_INSERT_AFTER, 8'h11, 5, 1'b0);   // position equals length
      queue_command(OP_DELETE, 8'hFF, 0, 1'b0);         // duplicate: front one goes
      queue_command(OP_GET, 8'h00, 3, 1'b0);
      queue_command(OP_DELETE, 8'h77, 0, 1'b0);
      // fill up, then hit the full list
      while (list_plan.count < CAPACITY)
         queue_command(OP_APPEND, 8'h10 + list_plan.count * 8'h0F, 0, 1'b0);
      queue_command(OP_APPEND, 8'hC3, 0, 1'b0);
      queue_command(OP_INSERT_AFTER, 8'h3C, 15, 1'b0);
      queue_command(OP_GET, 8'h00, 15, 1'b0);

      // random: grow and shrink phases, mostly in-range positions and present values
      growing = 1'b0;
      narrow = 1'b0;
      for (n = 0; n < RANDOM_COMMANDS; n++) begin
         len = list_plan.count;
         if (len == CAPACITY)
            growing = 1'b0;
         else if (len == 0)
            growing = 1'b1;
         else if ($urandom_range(0, 99) < 3)
            growing = !growing;
         if ($urandom_range(0, 49) == 0)
            narrow = !narrow;
         if ($urandom_range(0, 9) == 0) begin
            op = op_type'($urandom_range(0, 3));
            value = $urandom_range(0, 255);
            position = $urandom_range(0, 15);
         end else begin
            roll = $urandom_range(0, 99);
            if (growing)
               op = roll < 40 ? OP_APPEND : roll < 75 ? OP_INSERT_AFTER :
                    roll < 85 ? OP_DELETE : OP_GET;
            else
               op = roll < 15 ? OP_APPEND : roll < 30 ? OP_INSERT_AFTER :
                    roll < 75 ? OP_DELETE : OP_GET;
            value = narrow ? $urandom_range(0, 3) : $urandom_range(0, 255);
            position = len > 0 ? $urandom_range(0, len - 1) : 0;
            if (op == OP_DELETE && len > 0 && $urandom_range(0, 3) != 0)
               value = list_plan.bytes[$urandom_range(0, len - 1)];
         end
         queue_command(op, value, position, n == 250 || n == 900 || n == 1500);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0 || offering || expected_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d commands: append %0d, insert-after %0d, delete %0d, get %0d",
               results_seen, op_seen[OP_APPEND], op_seen[OP_INSERT_AFTER],
               op_seen[OP_DELETE], op_seen[OP_GET]);
      $display("outcomes: ok %0d, list full %0d, out of range %0d, not found %0d; faults %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
               status_seen[ST_NOT_FOUND], faults);
      if (faults == 0 && expected_results.size() == 0)
         $display("ordered_byte_list_unit regression: pass");
      else
         $display("ordered_byte_list_unit regression: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/obl_pkg.sv
design/obl_if.sv
design/obl_ram.sv
design/obl_seq.sv
design/obl_rsp_reg.sv
design/ordered_byte_list_unit.sv
tb/tb_ordered_byte_list_unit.sv
